@@ sv/sha_pkg.sv @@
package sha_pkg;

    localparam int unsigned BlockBytes = 64;
    localparam int unsigned Rounds     = 64;
    localparam int unsigned LenPos     = 56;
    localparam logic [7:0]  PadMark    = 8'h80;

    typedef logic [31:0] t_word;

    typedef struct packed {
        logic load_byte;
        logic load_pad;
        logic load_zero;
        logic load_len;
        logic start;
        logic reload_iv;
        logic clear_bits;
    } t_cmd;

    typedef struct packed {
        logic       busy;
        logic [5:0] fill;
    } t_status;

    function automatic t_word iv_word(input logic [2:0] idx);
        case (idx)
            3'd0: iv_word = 32'h6a09e667;
            3'd1: iv_word = 32'hbb67ae85;
            3'd2: iv_word = 32'h3c6ef372;
            3'd3: iv_word = 32'ha54ff53a;
            3'd4: iv_word = 32'h510e527f;
            3'd5: iv_word = 32'h9b05688c;
            3'd6: iv_word = 32'h1f83d9ab;
            default: iv_word = 32'h5be0cd19;
        endcase
    endfunction

    localparam t_word RoundK [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic t_word rotr(input t_word x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

@@ sv/sha_if.sv @@
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] data_byte;
    modport source (output valid, mode, data_byte, input ready);
    modport sink (input valid, mode, data_byte, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

@@ sv/sha256_byte_stream_hasher.sv @@
// SHA-256 hasher over a byte stream.
// Input channel in_if: one byte per handshake; mode 0 appends data_byte to
// the message, mode 1 finishes the message.
// Output channel out_if: a finish yields eight digest words, H0 first, with
// word_index 0..7 and last_word set on the eighth.
// Every data byte is taken while idle; the 64th byte of a block starts the
// 64-round compression (one round per cycle on a single round unit); input is
// held off until it ends.
// A finish writes the padding one byte per cycle into the block buffer,
// pausing while a first block is compressed, and runs one or two compressions,
// then presents the digest.
// Output words are held while the receiver stalls; no input is taken until
// all eight are taken. The hash state then reloads for the next message.
// Reset (i_rst_n low, synchronous) loads the initial hash values, clears the
// bit count and returns to idle; the block buffer needs no clearing.
module sha256_byte_stream_hasher (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sha_in_if.sink    in_if,
    sha_out_if.source out_if
);
    import sha_pkg::*;

    t_cmd       cmd;
    t_status    status;
    logic [7:0] wr_byte;
    logic [2:0] rd_idx;
    t_word      hash;

    sha_control u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .in_if    (in_if),
        .out_if   (out_if),
        .i_status (status),
        .i_hash   (hash),
        .o_cmd    (cmd),
        .o_byte   (wr_byte),
        .o_rd_idx (rd_idx)
    );

    sha_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_byte   (wr_byte),
        .i_rd_idx (rd_idx),
        .o_status (status),
        .o_hash   (hash)
    );

endmodule

@@ sv/sha_datapath.sv @@
module sha_datapath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sha_pkg::t_cmd  i_cmd,
    input  logic [7:0]     i_byte,
    input  logic [2:0]     i_rd_idx,
    output sha_pkg::t_status o_status,
    output logic [31:0]    o_hash
);
    import sha_pkg::*;

    t_word       r_w [0:15];
    t_word       r_h [0:7];
    t_word       r_v [0:7];
    logic [63:0] r_bits;
    logic [5:0]  r_pos;
    logic [6:0]  r_round;
    logic        r_busy;
    logic [7:0]  n_wbyte;
    t_word       w_cur, w_new, t1, t2, e_s, a_s;
    logic [5:0]  rnd;

    assign rnd = r_round[5:0];
    assign o_status.busy = r_busy;
    assign o_status.fill = r_pos;
    assign o_hash = r_h[i_rd_idx];

    always_comb begin
        n_wbyte = i_byte;
        if (i_cmd.load_pad) begin
            n_wbyte = PadMark;
        end else if (i_cmd.load_zero) begin
            n_wbyte = 8'h00;
        end else if (i_cmd.load_len) begin
            n_wbyte = r_bits[8 * (7 - r_pos[2:0]) +: 8];
        end
    end

    always_comb begin
        w_new = (rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10)) + r_w[9]
              + (rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3)) + r_w[0];
        w_cur = (rnd < 6'd16) ? r_w[0] : w_new;
        e_s = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
        a_s = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
        t1 = r_v[7] + e_s + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + RoundK[rnd] + w_cur;
        t2 = a_s + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_h[i];
            end
        end else if (r_busy && !r_round[6]) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= w_cur;
            r_v[0] <= t1 + t2;
            r_v[1] <= r_v[0];
            r_v[2] <= r_v[1];
            r_v[3] <= r_v[2];
            r_v[4] <= r_v[3] + t1;
            r_v[5] <= r_v[4];
            r_v[6] <= r_v[5];
            r_v[7] <= r_v[6];
        end
        if (i_cmd.load_byte || i_cmd.load_pad || i_cmd.load_zero || i_cmd.load_len) begin
            r_w[r_pos[5:2]][8 * (3 - r_pos[1:0]) +: 8] <= n_wbyte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= iv_word(3'(i));
            end
            r_bits  <= '0;
            r_pos   <= '0;
            r_round <= '0;
            r_busy  <= 1'b0;
        end else begin
            if (i_cmd.load_byte || i_cmd.load_pad || i_cmd.load_zero || i_cmd.load_len) begin
                r_pos <= r_pos + 6'd1;
            end
            if (i_cmd.load_byte) begin
                r_bits <= r_bits + 64'd8;
            end
            if (i_cmd.start) begin
                r_busy  <= 1'b1;
                r_round <= '0;
            end else if (r_busy) begin
                if (r_round[6]) begin
                    for (int i = 0; i < 8; i++) begin
                        r_h[i] <= r_h[i] + r_v[i];
                    end
                    r_busy <= 1'b0;
                end else begin
                    r_round <= r_round + 7'd1;
                end
            end
            if (i_cmd.reload_iv) begin
                for (int i = 0; i < 8; i++) begin
                    r_h[i] <= iv_word(3'(i));
                end
            end
            if (i_cmd.clear_bits) begin
                r_bits <= '0;
                r_pos  <= '0;
            end
        end
    end

endmodule

@@ sv/sha_control.sv @@
module sha_control (
    input  logic             i_clk,
    input  logic             i_rst_n,
    sha_in_if.sink           in_if,
    sha_out_if.source        out_if,
    input  sha_pkg::t_status i_status,
    input  logic [31:0]      i_hash,
    output sha_pkg::t_cmd    o_cmd,
    output logic [7:0]       o_byte,
    output logic [2:0]       o_rd_idx
);
    import sha_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_COMP  = 8'b0000_0010,
        S_PAD   = 8'b0000_0100,
        S_ZERO  = 8'b0000_1000,
        S_LEN   = 8'b0001_0000,
        S_FCOMP = 8'b0010_0000,
        S_OUT   = 8'b0100_0000,
        S_WAIT  = 8'b1000_0000
    } t_state;

    t_state     r_state, n_state;
    logic       r_second, n_second;
    logic [2:0] r_idx, n_idx;
    logic       r_started, n_started;

    assign o_byte = in_if.data_byte;
    assign o_rd_idx = r_idx;
    assign in_if.ready = (r_state == S_IDLE);
    assign out_if.valid = (r_state == S_OUT);
    assign out_if.digest_word = i_hash;
    assign out_if.word_index = r_idx;
    assign out_if.last_word = (r_idx == 3'd7);

    always_comb begin
        n_state   = r_state;
        n_second  = r_second;
        n_idx     = r_idx;
        n_started = 1'b0;
        o_cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (in_if.valid) begin
                    if (!in_if.mode) begin
                        o_cmd.load_byte = 1'b1;
                        if (i_status.fill == 6'd63) begin
                            o_cmd.start = 1'b1;
                            n_state = S_COMP;
                        end
                    end else begin
                        n_state = S_PAD;
                    end
                end
            end
            S_COMP: begin
                if (!i_status.busy) begin
                    n_state = S_IDLE;
                end
            end
            S_PAD: begin
                o_cmd.load_pad = 1'b1;
                n_second = (i_status.fill >= 6'(LenPos));
                n_state = (i_status.fill == 6'd63) ? S_WAIT : S_ZERO;
                if (i_status.fill == 6'd63) begin
                    n_started = 1'b1;
                end
                if (i_status.fill == 6'(LenPos - 1)) begin
                    n_state = S_LEN;
                end
            end
            S_ZERO: begin
                o_cmd.load_zero = 1'b1;
                if (i_status.fill == 6'd63) begin
                    n_state = S_WAIT;
                    n_started = 1'b1;
                end else if (i_status.fill == 6'(LenPos - 1) && !r_second) begin
                    n_state = S_LEN;
                end
            end
            S_WAIT: begin
                if (r_started) begin
                    o_cmd.start = 1'b1;
                end else if (!i_status.busy) begin
                    n_second = 1'b0;
                    n_state = S_ZERO;
                    if (i_status.fill == 6'(LenPos)) begin
                        n_state = S_LEN;
                    end
                end
            end
            S_LEN: begin
                o_cmd.load_len = 1'b1;
                if (i_status.fill == 6'd63) begin
                    n_state = S_FCOMP;
                    n_started = 1'b1;
                end
            end
            S_FCOMP: begin
                if (r_started) begin
                    o_cmd.start = 1'b1;
                end else if (!i_status.busy) begin
                    n_idx = 3'd0;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_if.ready) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        o_cmd.reload_iv = 1'b1;
                        o_cmd.clear_bits = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_second  <= 1'b0;
            r_idx     <= '0;
            r_started <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_second  <= n_second;
            r_idx     <= n_idx;
            r_started <= n_started;
        end
    end

endmodule
